>>> hw/rtl/quaternion_vector_rotate_top_assert.svh
// Assertion macros shared by the rotation block.
`ifndef QUATERNION_VECTOR_ROTATE_TOP_ASSERT_SVH
`define QUATERNION_VECTOR_ROTATE_TOP_ASSERT_SVH

// Same-cycle implication under synchronous active-low reset.
`define QVR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qvr assertion failed");

// Next-cycle implication under synchronous active-low reset.
`define QVR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qvr assertion failed");

`endif

>>> hw/rtl/qvr_pkg.sv
// Shared widths, constants and types of the quaternion rotation block.
`timescale 1ns / 1ps
package qvr_pkg;
    localparam int Q_W   = 16;
    localparam int V_W   = 24;
    localparam int T_W   = 42;
    localparam int P_W   = 60;
    localparam int REM_W = P_W - 1;
    localparam int N_W   = 33;
    localparam int QUO_W = 26;

    localparam logic signed [V_W-1:0] OUT_MAX = 24'sd8388607;
    localparam logic signed [V_W-1:0] OUT_MIN = -24'sd8388608;
    localparam logic [QUO_W-1:0] MAG_POS_MAX = 26'd8388607;
    localparam logic [QUO_W-1:0] MAG_NEG_MAX = 26'd8388608;

    typedef struct packed {
        logic [REM_W-1:0] dividend;
        logic [N_W-1:0]   divisor;
    } t_div_req;
endpackage

>>> hw/rtl/qvr_in_if.sv
// Input channel: quaternion and vector.
`timescale 1ns / 1ps
interface qvr_in_if;
    logic valid;
    logic ready;
    logic signed [qvr_pkg::Q_W-1:0] qx;
    logic signed [qvr_pkg::Q_W-1:0] qy;
    logic signed [qvr_pkg::Q_W-1:0] qz;
    logic signed [qvr_pkg::Q_W-1:0] qw;
    logic signed [qvr_pkg::V_W-1:0] vx;
    logic signed [qvr_pkg::V_W-1:0] vy;
    logic signed [qvr_pkg::V_W-1:0] vz;
    modport source (output valid, qx, qy, qz, qw, vx, vy, vz, input ready);
    modport sink   (input valid, qx, qy, qz, qw, vx, vy, vz, output ready);
endinterface

>>> hw/rtl/qvr_out_if.sv
// Output channel: rotated vector and flags.
`timescale 1ns / 1ps
interface qvr_out_if;
    logic valid;
    logic ready;
    logic signed [qvr_pkg::V_W-1:0] out_x;
    logic signed [qvr_pkg::V_W-1:0] out_y;
    logic signed [qvr_pkg::V_W-1:0] out_z;
    logic zero_quat;
    logic saturated;
    modport source (output valid, out_x, out_y, out_z, zero_quat, saturated, input ready);
    modport sink   (input valid, out_x, out_y, out_z, zero_quat, saturated, output ready);
endinterface

>>> hw/rtl/qvr_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module qvr_div (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  qvr_pkg::t_div_req            i_req,
    output logic [qvr_pkg::QUO_W-1:0]    o_quo
);
    localparam int RW = qvr_pkg::REM_W;
    localparam int NW = qvr_pkg::N_W;
    localparam int QW = qvr_pkg::QUO_W;

    logic [RW-1:0] r_rem [QW];
    logic [QW-1:0] r_quo [QW];
    logic [NW-1:0] r_den [QW];

    for (genvar s = 0; s < QW; s++) begin : g_stage
        localparam int B = QW - 1 - s;
        logic [RW-1:0] rem_in;
        logic [QW-1:0] quo_in;
        logic [NW-1:0] den_in;
        logic [RW:0]   d;
        logic          ge;
        logic [RW-1:0] n_rem;
        logic [QW-1:0] n_quo;

        if (s == 0) begin : g_first
            assign rem_in = i_req.dividend;
            assign quo_in = '0;
            assign den_in = i_req.divisor;
        end else begin : g_next
            assign rem_in = r_rem[s-1];
            assign quo_in = r_quo[s-1];
            assign den_in = r_den[s-1];
        end

        always_comb begin
            d     = (RW+1)'(den_in) << B;
            ge    = {1'b0, rem_in} >= d;
            n_rem = ge ? RW'({1'b0, rem_in} - d) : rem_in;
            n_quo = quo_in | (QW'(ge) << B);
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= n_rem;
                r_quo[s] <= n_quo;
                r_den[s] <= den_in;
            end
        end
    end

    assign o_quo = r_quo[QW-1];
endmodule

>>> hw/rtl/quaternion_vector_rotate_top.sv
// Rotates a vector by a quaternion as q*v*conj(q)/|q|^2, one vector per cycle
// while the output is not stalled. Pipeline: input register, the two Hamilton product
// stages, 26 stages of the restoring divider (one quotient bit each, three
// lanes side by side) and the output register. The divider makes up most of the
// pipeline depth; a stalled output freezes the whole pipeline without losing data.
`timescale 1ns / 1ps
`include "quaternion_vector_rotate_top_assert.svh"
module quaternion_vector_rotate_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    qvr_in_if.sink     i_in,
    qvr_out_if.source  o_out
);
    localparam int QW = qvr_pkg::QUO_W;
    localparam int TW = qvr_pkg::T_W;
    localparam int PW = qvr_pkg::P_W;
    localparam int RW = qvr_pkg::REM_W;
    localparam int NW = qvr_pkg::N_W;
    localparam int VW = qvr_pkg::V_W;

    logic en;
    assign en = !o_out.valid || o_out.ready;
    assign i_in.ready = en;

    // stage 1: input register
    logic r1_vld;
    logic signed [qvr_pkg::Q_W-1:0] r1_qx, r1_qy, r1_qz, r1_qw;
    logic signed [VW-1:0] r1_vx, r1_vy, r1_vz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_in.valid;
        end
        if (en) begin
            r1_qx <= i_in.qx; r1_qy <= i_in.qy; r1_qz <= i_in.qz; r1_qw <= i_in.qw;
            r1_vx <= i_in.vx; r1_vy <= i_in.vy; r1_vz <= i_in.vz;
        end
    end

    // stage 2: t = q * (0,v) and the squared norm
    logic r2_vld;
    logic signed [TW-1:0] r2_t0, r2_t1, r2_t2, r2_t3;
    logic signed [qvr_pkg::Q_W-1:0] r2_qx, r2_qy, r2_qz, r2_qw;
    logic [NW-1:0] r2_n;
    logic signed [TW-1:0] n_t0, n_t1, n_t2, n_t3;
    logic signed [NW:0] n_norm;

    always_comb begin
        n_t0 = TW'(r1_qw) * TW'(r1_vx) + TW'(r1_qy) * TW'(r1_vz) - TW'(r1_qz) * TW'(r1_vy);
        n_t1 = TW'(r1_qw) * TW'(r1_vy) + TW'(r1_qz) * TW'(r1_vx) - TW'(r1_qx) * TW'(r1_vz);
        n_t2 = TW'(r1_qw) * TW'(r1_vz) + TW'(r1_qx) * TW'(r1_vy) - TW'(r1_qy) * TW'(r1_vx);
        n_t3 = -(TW'(r1_qx) * TW'(r1_vx)) - TW'(r1_qy) * TW'(r1_vy) - TW'(r1_qz) * TW'(r1_vz);
        n_norm = (NW+1)'(r1_qx) * (NW+1)'(r1_qx) + (NW+1)'(r1_qy) * (NW+1)'(r1_qy)
               + (NW+1)'(r1_qz) * (NW+1)'(r1_qz) + (NW+1)'(r1_qw) * (NW+1)'(r1_qw);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (en) begin
            r2_vld <= r1_vld;
        end
        if (en) begin
            r2_t0 <= n_t0; r2_t1 <= n_t1; r2_t2 <= n_t2; r2_t3 <= n_t3;
            r2_qx <= r1_qx; r2_qy <= r1_qy; r2_qz <= r1_qz; r2_qw <= r1_qw;
            r2_n  <= NW'(n_norm);
        end
    end

    // stage 3: p = t * conj(q), split into sign and magnitude
    logic r3_vld, r3_zq;
    logic [2:0] r3_sg;
    logic [RW-1:0] r3_m0, r3_m1, r3_m2;
    logic [NW-1:0] r3_n;
    logic signed [PW-1:0] n_p0, n_p1, n_p2, a0, a1, a2;

    always_comb begin
        n_p0 = PW'(r2_t0) * PW'(r2_qw) - PW'(r2_t3) * PW'(r2_qx)
             - PW'(r2_t1) * PW'(r2_qz) + PW'(r2_t2) * PW'(r2_qy);
        n_p1 = PW'(r2_t1) * PW'(r2_qw) - PW'(r2_t3) * PW'(r2_qy)
             - PW'(r2_t2) * PW'(r2_qx) + PW'(r2_t0) * PW'(r2_qz);
        n_p2 = PW'(r2_t2) * PW'(r2_qw) - PW'(r2_t3) * PW'(r2_qz)
             - PW'(r2_t0) * PW'(r2_qy) + PW'(r2_t1) * PW'(r2_qx);
        a0 = n_p0[PW-1] ? -n_p0 : n_p0;
        a1 = n_p1[PW-1] ? -n_p1 : n_p1;
        a2 = n_p2[PW-1] ? -n_p2 : n_p2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (en) begin
            r3_vld <= r2_vld;
        end
        if (en) begin
            r3_sg <= {n_p2[PW-1], n_p1[PW-1], n_p0[PW-1]};
            r3_m0 <= a0[RW-1:0]; r3_m1 <= a1[RW-1:0]; r3_m2 <= a2[RW-1:0];
            r3_n  <= r2_n;
            r3_zq <= (r2_n == '0);
        end
    end

    // divider lanes with side data carried alongside
    qvr_pkg::t_div_req req0, req1, req2;
    logic [QW-1:0] quo0, quo1, quo2;
    assign req0 = '{dividend: r3_m0, divisor: r3_n};
    assign req1 = '{dividend: r3_m1, divisor: r3_n};
    assign req2 = '{dividend: r3_m2, divisor: r3_n};

    qvr_div u_div0 (.i_clk(i_clk), .i_en(en), .i_req(req0), .o_quo(quo0));
    qvr_div u_div1 (.i_clk(i_clk), .i_en(en), .i_req(req1), .o_quo(quo1));
    qvr_div u_div2 (.i_clk(i_clk), .i_en(en), .i_req(req2), .o_quo(quo2));

    logic       r_dv  [QW];
    logic       r_dzq [QW];
    logic [2:0] r_dsg [QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < QW; s++) r_dv[s] <= 1'b0;
        end else if (en) begin
            r_dv[0] <= r3_vld;
            for (int s = 1; s < QW; s++) r_dv[s] <= r_dv[s-1];
        end
        if (en) begin
            r_dzq[0] <= r3_zq;
            r_dsg[0] <= r3_sg;
            for (int s = 1; s < QW; s++) begin
                r_dzq[s] <= r_dzq[s-1];
                r_dsg[s] <= r_dsg[s-1];
            end
        end
    end

    // output stage: restore sign, saturate, force zero on a zero quaternion
    function automatic logic [VW:0] fix_sign(input logic [QW-1:0] mag, input logic neg);
        logic [VW:0] res;
        if (neg) begin
            if (mag > qvr_pkg::MAG_NEG_MAX) res = {1'b1, qvr_pkg::OUT_MIN};
            else res = {1'b0, VW'(-mag)};
        end else begin
            if (mag > qvr_pkg::MAG_POS_MAX) res = {1'b1, qvr_pkg::OUT_MAX};
            else res = {1'b0, mag[VW-1:0]};
        end
        return res;
    endfunction

    logic [VW:0] f0, f1, f2;
    logic r_ovld;
    logic signed [VW-1:0] r_ox, r_oy, r_oz;
    logic r_ozq, r_osat;
    logic last_zq;

    always_comb begin
        f0 = fix_sign(quo0, r_dsg[QW-1][0]);
        f1 = fix_sign(quo1, r_dsg[QW-1][1]);
        f2 = fix_sign(quo2, r_dsg[QW-1][2]);
        last_zq = r_dzq[QW-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (en) begin
            r_ovld <= r_dv[QW-1];
        end
        if (en) begin
            r_ox   <= last_zq ? '0 : f0[VW-1:0];
            r_oy   <= last_zq ? '0 : f1[VW-1:0];
            r_oz   <= last_zq ? '0 : f2[VW-1:0];
            r_ozq  <= last_zq;
            r_osat <= !last_zq && (f0[VW] || f1[VW] || f2[VW]);
        end
    end

    assign o_out.valid     = r_ovld;
    assign o_out.out_x     = r_ox;
    assign o_out.out_y     = r_oy;
    assign o_out.out_z     = r_oz;
    assign o_out.zero_quat = r_ozq;
    assign o_out.saturated = r_osat;

    `QVR_ASSERT_IMP(a_zero_out, i_clk, i_rst_n, o_out.valid && o_out.zero_quat,
        o_out.out_x == '0 && o_out.out_y == '0 && o_out.out_z == '0 && !o_out.saturated)
    `QVR_ASSERT_IMP(a_sat_bound, i_clk, i_rst_n, o_out.valid && o_out.saturated,
        o_out.out_x == qvr_pkg::OUT_MAX || o_out.out_x == qvr_pkg::OUT_MIN ||
        o_out.out_y == qvr_pkg::OUT_MAX || o_out.out_y == qvr_pkg::OUT_MIN ||
        o_out.out_z == qvr_pkg::OUT_MAX || o_out.out_z == qvr_pkg::OUT_MIN)
    `QVR_ASSERT_NXT(a_div_to_out, i_clk, i_rst_n, en && r_dv[QW-1], o_out.valid)
endmodule

>>> tb/quaternion_vector_rotate_top_tb.sv
// Testbench for the quaternion vector rotation block with a behavioral predictor.
`timescale 1ns / 1ps
module quaternion_vector_rotate_top_tb;

    typedef struct {
        logic signed [qvr_pkg::V_W-1:0] x;
        logic signed [qvr_pkg::V_W-1:0] y;
        logic signed [qvr_pkg::V_W-1:0] z;
        logic                           zq;
        logic                           sat;
    } t_rot_result;

    class t_rotation_scoreboard;
        t_rot_result pending_q[$];
        int errors;
        int checked;
        int zero_seen;
        int sat_seen;

        function automatic longint clamp24(longint v, ref bit clipped);
            if (v > longint'(qvr_pkg::OUT_MAX)) begin
                clipped = 1;
                return longint'(qvr_pkg::OUT_MAX);
            end
            if (v < longint'(qvr_pkg::OUT_MIN)) begin
                clipped = 1;
                return longint'(qvr_pkg::OUT_MIN);
            end
            return v;
        endfunction

        function void note_input(logic signed [qvr_pkg::Q_W-1:0] qx,
                                 logic signed [qvr_pkg::Q_W-1:0] qy,
                                 logic signed [qvr_pkg::Q_W-1:0] qz,
                                 logic signed [qvr_pkg::Q_W-1:0] qw,
                                 logic signed [qvr_pkg::V_W-1:0] vx,
                                 logic signed [qvr_pkg::V_W-1:0] vy,
                                 logic signed [qvr_pkg::V_W-1:0] vz);
            longint a, b, c, d, x, y, z, norm;
            longint tx, ty, tz, tw, px, py, pz;
            bit clipped;
            t_rot_result r;
            a = qx; b = qy; c = qz; d = qw;
            x = vx; y = vy; z = vz;
            clipped = 0;
            norm = a*a + b*b + c*c + d*d;
            if (norm == 0) begin
                r.x = '0; r.y = '0; r.z = '0; r.zq = 1; r.sat = 0;
            end else begin
                // t = q * (0,v)
                tx = d*x + b*z - c*y;
                ty = d*y + c*x - a*z;
                tz = d*z + a*y - b*x;
                tw = -a*x - b*y - c*z;
                // p = t * conj(q)
                px = -tw*a + tx*d - ty*c + tz*b;
                py = -tw*b + ty*d - tz*a + tx*c;
                pz = -tw*c + tz*d - tx*b + ty*a;
                r.x = qvr_pkg::V_W'(clamp24(px / norm, clipped));
                r.y = qvr_pkg::V_W'(clamp24(py / norm, clipped));
                r.z = qvr_pkg::V_W'(clamp24(pz / norm, clipped));
                r.zq = 0;
                r.sat = clipped;
            end
            pending_q.push_back(r);
        endfunction

        function void check_result(logic signed [qvr_pkg::V_W-1:0] x,
                                   logic signed [qvr_pkg::V_W-1:0] y,
                                   logic signed [qvr_pkg::V_W-1:0] z, logic zq, logic sat);
            t_rot_result e;
            checked++;
            if (zq) zero_seen++;
            if (sat) sat_seen++;
            if (pending_q.size() == 0) begin
                $display("%0t: result expected none actual x=%0d y=%0d z=%0d",
                         $time, x, y, z);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (x !== e.x) begin
                $display("%0t: out_x expected %0d actual %0d", $time, e.x, x);
                errors++;
            end
            if (y !== e.y) begin
                $display("%0t: out_y expected %0d actual %0d", $time, e.y, y);
                errors++;
            end
            if (z !== e.z) begin
                $display("%0t: out_z expected %0d actual %0d", $time, e.z, z);
                errors++;
            end
            if (zq !== e.zq) begin
                $display("%0t: zero_quat expected %0b actual %0b", $time, e.zq, zq);
                errors++;
            end
            if (sat !== e.sat) begin
                $display("%0t: saturated expected %0b actual %0b", $time, e.sat, sat);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    qvr_in_if  in_ch();
    qvr_out_if out_ch();

    quaternion_vector_rotate_top u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    t_rotation_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_off_cycles;
    int sent;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // note accepted transactions and check results at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready)
                sb.note_input(in_ch.qx, in_ch.qy, in_ch.qz, in_ch.qw,
                              in_ch.vx, in_ch.vy, in_ch.vz);
            if (out_ch.valid && out_ch.ready)
                sb.check_result(out_ch.out_x, out_ch.out_y, out_ch.out_z,
                                out_ch.zero_quat, out_ch.saturated);
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        out_ch.ready = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off_cycles > 0) begin
                out_ch.ready <= 0;
                hold_off_cycles--;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic send_item(logic [qvr_pkg::Q_W-1:0] qx, logic [qvr_pkg::Q_W-1:0] qy,
                             logic [qvr_pkg::Q_W-1:0] qz, logic [qvr_pkg::Q_W-1:0] qw,
                             logic [qvr_pkg::V_W-1:0] vx, logic [qvr_pkg::V_W-1:0] vy,
                             logic [qvr_pkg::V_W-1:0] vz);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1;
        in_ch.qx <= qx; in_ch.qy <= qy; in_ch.qz <= qz; in_ch.qw <= qw;
        in_ch.vx <= vx; in_ch.vy <= vy; in_ch.vz <= vz;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        sent++;
    endtask

    task automatic send_random();
        logic [qvr_pkg::Q_W-1:0] q[4];
        logic [qvr_pkg::V_W-1:0] v[3];
        int k;
        k = $urandom_range(9);
        foreach (q[i]) q[i] = qvr_pkg::Q_W'($urandom);
        foreach (v[i]) v[i] = qvr_pkg::V_W'($urandom);
        if (k < 4) begin
            // near-unit quaternion: small components except one
            foreach (q[i]) q[i] = qvr_pkg::Q_W'($signed($urandom_range(8191)) - 4096);
            q[$urandom_range(3)] = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
        end else if (k == 4) begin
            // tiny norm forces big quotients and clipping
            foreach (q[i]) q[i] = qvr_pkg::Q_W'($signed($urandom_range(4)) - 2);
        end else if (k == 5) begin
            foreach (v[i]) v[i] = qvr_pkg::V_W'($signed($urandom_range(200)) - 100);
        end
        send_item(q[0], q[1], q[2], q[3], v[0], v[1], v[2]);
    endtask

    task automatic drain();
        int guard;
        in_ch.valid <= 0;
        guard = 0;
        while (sb.pending_q.size() != 0 && guard < 200000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (40) @(negedge i_clk);
    endtask

    initial begin
        logic [qvr_pkg::Q_W-1:0] qmax, qmin;
        logic [qvr_pkg::V_W-1:0] vmax, vmin;
        sb = new();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        sent = 0;
        i_rst_n = 0;
        in_ch.valid = 0;
        in_ch.qx = 0; in_ch.qy = 0; in_ch.qz = 0; in_ch.qw = 0;
        in_ch.vx = 0; in_ch.vy = 0; in_ch.vz = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        qmax = 16'h7fff; qmin = 16'h8000;
        vmax = 24'h7fffff; vmin = 24'h800000;
        // directed: identity, zero quaternion, extremes, 90-degree turns, clipping
        send_item(0, 0, 0, 16384, 1000, -2000, 3000);
        send_item(0, 0, 0, 0, vmax, vmin, 5);
        send_item(0, 0, 0, 0, 0, 0, 0);
        send_item(0, 0, 0, qmax, vmax, vmin, vmax);
        send_item(0, 0, 0, qmin, vmin, vmin, vmin);
        send_item(qmax, qmax, qmax, qmax, vmax, vmax, vmax);
        send_item(qmin, qmin, qmin, qmin, vmin, vmin, vmin);
        send_item(qmax, qmin, qmax, qmin, vmin, vmax, vmin);
        send_item(11585, 0, 0, 11585, 0, vmax, 0);
        send_item(0, 11585, 0, 11585, vmax, 0, vmin);
        send_item(0, 0, 11585, 11585, vmin, vmax, 0);
        send_item(16384, 0, 0, 0, 1, 2, 3);
        send_item(1, 0, 0, 0, vmax, vmax, vmax);
        send_item(1, 1, 1, 1, vmax, vmin, vmax);
        send_item(16'hffff, 0, 0, 0, vmin, 0, 1);
        send_item(9459, 9459, 9459, 0, vmax, vmin, 0);
        send_item(qmin, 0, 0, 0, -1, -1, -1);
        send_item(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 24'h555555, 24'haaaaaa, 24'h555555);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
                default: begin send_idle_pct = 23; recv_stall_pct = 23; end
            endcase
            for (int n = 0; n < 150; n++) begin
                // fill the pipeline against a stalled output
                if (ph == 0 && n == 50) hold_off_cycles = 120;
                send_random();
            end
        end
        drain();

        $display("Sent %0d vectors, checked %0d results (%0d zero-quaternion, %0d clipped).",
                 sent, sb.checked, sb.zero_seen, sb.sat_seen);
        $display("Phases: full rate, sparse input, stalled output, mixed gaps, one long hold-off.");
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/qvr_pkg.sv
hw/rtl/qvr_in_if.sv
hw/rtl/qvr_out_if.sv
hw/rtl/qvr_div.sv
hw/rtl/quaternion_vector_rotate_top.sv
tb/quaternion_vector_rotate_top_tb.sv
